// ===== hdl/elevator_floor_scheduler_defines.svh =====
// assertion macros shared by the scheduler rtl
// no dependencies; taken in by the modules that carry assertions
`ifndef ELEVATOR_FLOOR_SCHEDULER_DEFINES_SVH
`define ELEVATOR_FLOOR_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define EFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
`define EFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define EFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EFS_ASSERT(lbl, prop, msg)
`define EFS_ASSERT_IMP(lbl, ante, cons, msg)
`define EFS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/efs_pkg.sv =====
// types, codes and constants of the elevator floor scheduler
// no dependencies; used by the interfaces, controller, datapath and top level
package efs_pkg;

    localparam int FLOOR_COUNT_DEF = 16;

    localparam int MODE_W  = 2;
    localparam int FLOOR_W = 4;
    localparam int KIND_W  = 2;
    localparam int DIR_W   = 2;

    // input modes
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HALL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CAR  = 2'd2;

    // stop kinds
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BOARD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALIGHT = 2'd2;

    // travel directions
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_CALL
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic scan_init;
        logic scan_step;
        logic do_move;
        logic do_call;
    } t_cmd;

    typedef struct packed {
        logic in_is_tick;
        logic scan_last;
    } t_stat;

endpackage

// ===== hdl/efs_in_if.sv =====
// input channel of the scheduler: valid/ready with mode and floor
// depends on efs_pkg
interface efs_in_if;
    logic                        valid;
    logic                        ready;
    logic [efs_pkg::MODE_W-1:0]  mode;
    logic [efs_pkg::FLOOR_W-1:0] floor;

    modport source (output valid, output mode, output floor, input ready);
    modport sink   (input valid, input mode, input floor, output ready);
endinterface

// ===== hdl/efs_out_if.sv =====
// result channel of the scheduler: valid/ready with stop kind, floor and direction
// depends on efs_pkg
interface efs_out_if;
    logic                        valid;
    logic                        ready;
    logic [efs_pkg::KIND_W-1:0]  stop_kind;
    logic [efs_pkg::FLOOR_W-1:0] floor_now;
    logic [efs_pkg::DIR_W-1:0]   direction;

    modport source (output valid, output stop_kind, output floor_now, output direction,
                    input ready);
    modport sink   (input valid, input stop_kind, input floor_now, input direction,
                    output ready);
endinterface

// ===== hdl/efs_ctrl.sv =====
// controller state machine of the scheduler: handshakes, scan sequencing
// depends on efs_pkg and elevator_floor_scheduler_defines.svh
`include "elevator_floor_scheduler_defines.svh"

module efs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  efs_pkg::t_stat i_stat,
    output efs_pkg::t_cmd  o_cmd
);

    efs_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            in_acc;
    logic            slot_free;

    assign in_acc    = i_in_valid && (r_state == efs_pkg::ST_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= efs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            efs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc) begin
                    o_cmd.latch_in = 1'b1;
                    if (i_stat.in_is_tick) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = efs_pkg::ST_SCAN;
                    end else begin
                        n_state = efs_pkg::ST_CALL;
                    end
                end
            end
            efs_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = efs_pkg::ST_MOVE;
                end
            end
            efs_pkg::ST_MOVE: begin
                if (slot_free) begin
                    o_cmd.do_move = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = efs_pkg::ST_IDLE;
                end
            end
            efs_pkg::ST_CALL: begin
                if (slot_free) begin
                    o_cmd.do_call = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = efs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = efs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `EFS_ASSERT_IMP(a_load_src, $rose(r_out_valid),
        $past(r_state == efs_pkg::ST_MOVE || r_state == efs_pkg::ST_CALL),
        "result appeared without a move or call step")
    `EFS_ASSERT_NXT(a_acc_busy, in_acc, r_state != efs_pkg::ST_IDLE,
        "accepted transaction did not leave idle")
    `EFS_ASSERT_NXT(a_scan_end, r_state == efs_pkg::ST_SCAN && i_stat.scan_last,
        r_state == efs_pkg::ST_MOVE, "scan end did not lead to move")

endmodule

// ===== hdl/efs_dp.sv =====
// datapath of the scheduler: car floor, direction, call flags, floor scan, result register
// depends on efs_pkg and elevator_floor_scheduler_defines.svh
`include "elevator_floor_scheduler_defines.svh"

module efs_dp #(
    parameter int FLOOR_COUNT = efs_pkg::FLOOR_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [efs_pkg::MODE_W-1:0]  i_in_mode,
    input  logic [efs_pkg::FLOOR_W-1:0] i_in_floor,
    input  efs_pkg::t_cmd               i_cmd,
    output efs_pkg::t_stat              o_stat,
    output logic [efs_pkg::KIND_W-1:0]  o_stop_kind,
    output logic [efs_pkg::FLOOR_W-1:0] o_floor_now,
    output logic [efs_pkg::DIR_W-1:0]   o_direction
);

    localparam int FLW  = (FLOOR_COUNT > 1) ? $clog2(FLOOR_COUNT) : 1;
    localparam int CMPW = (FLW > efs_pkg::FLOOR_W) ? FLW : efs_pkg::FLOOR_W;
    localparam logic [FLW-1:0]         TOP      = FLW'(FLOOR_COUNT - 1);
    localparam logic [FLOOR_COUNT-1:0] ONE_FLAG = FLOOR_COUNT'(1);

    // architectural state
    logic [FLW-1:0]           r_car, n_car;
    logic [efs_pkg::DIR_W-1:0] r_dir, n_dir;
    logic [FLOOR_COUNT-1:0]   r_hall, n_hall;
    logic [FLOOR_COUNT-1:0]   r_creq, n_creq;

    // latched item and scan state
    logic [efs_pkg::MODE_W-1:0]  r_mode;
    logic [efs_pkg::FLOOR_W-1:0] r_floor;
    logic [FLW-1:0]              r_d, n_d;
    logic                        r_any_up, n_any_up;
    logic                        r_any_dn, n_any_dn;
    logic [efs_pkg::DIR_W-1:0]   r_cdec, n_cdec;
    logic [efs_pkg::DIR_W-1:0]   r_hdec, n_hdec;

    // result register
    logic [efs_pkg::KIND_W-1:0]  r_o_kind, n_o_kind;
    logic [efs_pkg::FLOOR_W-1:0] r_o_floor, n_o_floor;
    logic [efs_pkg::DIR_W-1:0]   r_o_dir, n_o_dir;

    // scan step
    logic [FLW-1:0] up_room, up_idx, dn_idx;
    logic           up_ok, dn_ok, c_up, c_dn, h_up, h_dn;

    // call decode
    logic [CMPW-1:0]        floor_x, car_x;
    logic                   is_call, in_range, at_car;
    logic [FLOOR_COUNT-1:0] call_mask;

    // move
    logic [efs_pkg::DIR_W-1:0] mv_dir;
    logic [FLW-1:0]            mv_floor;
    logic [FLOOR_COUNT-1:0]    mv_mask;
    logic [efs_pkg::KIND_W-1:0] mv_kind;
    logic [CMPW-1:0]           mv_floor_x;

    assign up_room = TOP - r_car;
    assign up_ok   = r_d <= up_room;
    assign dn_ok   = r_d <= r_car;
    assign up_idx  = r_car + r_d;
    assign dn_idx  = r_car - r_d;
    assign c_up    = up_ok && r_creq[up_idx];
    assign c_dn    = dn_ok && r_creq[dn_idx];
    assign h_up    = up_ok && r_hall[up_idx];
    assign h_dn    = dn_ok && r_hall[dn_idx];

    assign o_stat.in_is_tick = (i_in_mode == efs_pkg::MODE_TICK);
    assign o_stat.scan_last  = (r_d >= r_car) && (r_d >= up_room);

    assign floor_x   = CMPW'(r_floor);
    assign car_x     = CMPW'(r_car);
    assign is_call   = (r_mode == efs_pkg::MODE_HALL) || (r_mode == efs_pkg::MODE_CAR);
    assign in_range  = floor_x <= CMPW'(TOP);
    assign at_car    = floor_x == car_x;
    assign call_mask = ONE_FLAG << floor_x[FLW-1:0];

    // keep heading while work lies ahead, else nearest car request, then nearest hall call
    always_comb begin
        if (r_dir == efs_pkg::DIR_DOWN && r_any_dn) begin
            mv_dir = efs_pkg::DIR_DOWN;
        end else if (r_dir == efs_pkg::DIR_UP && r_any_up) begin
            mv_dir = efs_pkg::DIR_UP;
        end else if (r_cdec != efs_pkg::DIR_STOP) begin
            mv_dir = r_cdec;
        end else begin
            mv_dir = r_hdec;
        end
        mv_floor = r_car;
        if (mv_dir == efs_pkg::DIR_DOWN && r_car != '0) begin
            mv_floor = r_car - FLW'(1);
        end else if (mv_dir == efs_pkg::DIR_UP && r_car != TOP) begin
            mv_floor = r_car + FLW'(1);
        end
        mv_mask = ONE_FLAG << mv_floor;
        if (r_hall[mv_floor]) begin
            mv_kind = efs_pkg::KIND_BOARD;
        end else if (r_creq[mv_floor]) begin
            mv_kind = efs_pkg::KIND_ALIGHT;
        end else begin
            mv_kind = efs_pkg::KIND_NONE;
        end
    end

    assign mv_floor_x = CMPW'(mv_floor);

    always_comb begin
        n_car     = r_car;
        n_dir     = r_dir;
        n_hall    = r_hall;
        n_creq    = r_creq;
        n_d       = r_d;
        n_any_up  = r_any_up;
        n_any_dn  = r_any_dn;
        n_cdec    = r_cdec;
        n_hdec    = r_hdec;
        n_o_kind  = r_o_kind;
        n_o_floor = r_o_floor;
        n_o_dir   = r_o_dir;
        if (i_cmd.scan_init) begin
            n_d      = FLW'(1);
            n_any_up = 1'b0;
            n_any_dn = 1'b0;
            n_cdec   = efs_pkg::DIR_STOP;
            n_hdec   = efs_pkg::DIR_STOP;
        end
        if (i_cmd.scan_step) begin
            n_d      = r_d + FLW'(1);
            n_any_up = r_any_up || c_up || h_up;
            n_any_dn = r_any_dn || c_dn || h_dn;
            if (r_cdec == efs_pkg::DIR_STOP) begin
                if (c_up) begin
                    n_cdec = efs_pkg::DIR_UP;
                end else if (c_dn) begin
                    n_cdec = efs_pkg::DIR_DOWN;
                end
            end
            if (r_hdec == efs_pkg::DIR_STOP) begin
                if (h_up) begin
                    n_hdec = efs_pkg::DIR_UP;
                end else if (h_dn) begin
                    n_hdec = efs_pkg::DIR_DOWN;
                end
            end
        end
        if (i_cmd.do_move) begin
            n_car     = mv_floor;
            n_dir     = mv_dir;
            n_hall    = r_hall & ~mv_mask;
            n_creq    = r_creq & ~mv_mask;
            n_o_kind  = mv_kind;
            n_o_floor = mv_floor_x[efs_pkg::FLOOR_W-1:0];
            n_o_dir   = mv_dir;
        end
        if (i_cmd.do_call) begin
            n_o_kind  = efs_pkg::KIND_NONE;
            n_o_floor = car_x[efs_pkg::FLOOR_W-1:0];
            n_o_dir   = r_dir;
            if (is_call && in_range) begin
                if (at_car) begin
                    n_o_kind = (r_mode == efs_pkg::MODE_HALL) ? efs_pkg::KIND_BOARD
                                                              : efs_pkg::KIND_ALIGHT;
                end else if (r_mode == efs_pkg::MODE_HALL) begin
                    n_hall = r_hall | call_mask;
                end else begin
                    n_creq = r_creq | call_mask;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car  <= '0;
            r_dir  <= efs_pkg::DIR_STOP;
            r_hall <= '0;
            r_creq <= '0;
        end else begin
            r_car  <= n_car;
            r_dir  <= n_dir;
            r_hall <= n_hall;
            r_creq <= n_creq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_mode  <= i_in_mode;
            r_floor <= i_in_floor;
        end
        r_d       <= n_d;
        r_any_up  <= n_any_up;
        r_any_dn  <= n_any_dn;
        r_cdec    <= n_cdec;
        r_hdec    <= n_hdec;
        r_o_kind  <= n_o_kind;
        r_o_floor <= n_o_floor;
        r_o_dir   <= n_o_dir;
    end

    assign o_stop_kind = r_o_kind;
    assign o_floor_now = r_o_floor;
    assign o_direction = r_o_dir;

    `EFS_ASSERT(a_car_range, r_car <= TOP, "car floor outside the building")
    `EFS_ASSERT(a_no_flag_here, !(r_hall[r_car] || r_creq[r_car]),
        "call flag stored at the car floor")
    `EFS_ASSERT_NXT(a_one_floor, i_cmd.do_move,
        (r_car == $past(r_car)) || (r_car == $past(r_car) + FLW'(1))
        || (r_car == $past(r_car) - FLW'(1)), "car moved more than one floor")

endmodule

// ===== hdl/elevator_floor_scheduler.sv =====
// top level of the single-car elevator floor scheduler
// depends on efs_pkg, efs_in_if, efs_out_if, efs_ctrl and efs_dp
//
// usage
// - i_in carries one transaction per event: mode tick moves the car, mode hall
//   or car registers a call at a floor; every input transaction yields exactly
//   one result transaction on o_out (stop kind, car floor, direction)
// - a hall or car transaction passes from idle to the call state to its result
// - a tick scans the call flags outward from the car, one distance a cycle in
//   both directions, until the distance reaches the farther end of the
//   building; the move state then moves the car at most one floor
// - one transaction is in work at a time; i_in.ready is high while idle, the
//   cycle after a result is loaded
// - results sit in an output register: a new transaction is taken while an
//   earlier result waits; if o_out is still stalled when the next result is
//   done, the block waits in the move or call state and keeps i_in.ready low
// - synchronous active-low reset puts the car at floor 0, stopped, with no
//   calls pending and no result valid
//
module elevator_floor_scheduler #(
    parameter int FLOOR_COUNT = efs_pkg::FLOOR_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    efs_in_if.sink    i_in,
    efs_out_if.source o_out
);

    // command and status between controller and datapath
    efs_pkg::t_cmd  cmd;
    efs_pkg::t_stat stat;

    // sequencing of handshakes, scan and update
    efs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // car state, call flags, floor scan and result register
    efs_dp #(
        .FLOOR_COUNT (FLOOR_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mode   (i_in.mode),
        .i_in_floor  (i_in.floor),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_stop_kind (o_out.stop_kind),
        .o_floor_now (o_out.floor_now),
        .o_direction (o_out.direction)
    );

endmodule
